// ===== hw/rtl/prpi_pkg.sv =====
// Shared constants and types for the PageRank power-iteration block.
package prpi_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int RANK_FRAC_DEF    = 32;

   localparam int DEG_W      = 7;
   localparam int DAMP_W     = 17;
   localparam int DAMP_SHIFT = 16;
   localparam int VC_W       = 7;
   localparam int EPS_W      = 32;
   localparam int ITER_W     = 16;
   localparam int FIELD_W    = 6;
   localparam int OUT_RANK_W = 33;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [DAMP_W-1:0] DAMP_ONE = 17'd65536;

   localparam logic [VC_W-1:0]   VC_RESET    = 7'd64;
   localparam logic [DAMP_W-1:0] DAMP_RESET  = 17'd55706;
   localparam logic [EPS_W-1:0]  EPS_RESET   = 32'd4295;
   localparam logic [ITER_W-1:0] MAXIT_RESET = 16'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VERTEX_COUNT = 2'd0,
      CSR_DAMPING      = 2'd1,
      CSR_EPSILON      = 2'd2,
      CSR_MAX_ITER     = 2'd3
   } csr_idx_type;

   // Field write enables of the vertex memory
   typedef struct packed {
      logic deg;
      logic rank;
      logic contrib;
   } vtx_we_type;

endpackage

// ===== hw/rtl/prpi_div.sv =====
// Restoring divider, one quotient bit per cycle.
module prpi_div import prpi_pkg::*; #(
   parameter int DW = 39,
   parameter int SW = DEG_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [SW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] q_ff, q_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW:0]   trial;
   logic [SW:0]   diffv;
   logic          ge;

   always_comb begin
      trial  = {rem_ff, q_ff[DW-1]};
      ge     = trial >= {1'b0, dsr_ff};
      diffv  = trial - {1'b0, dsr_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         q_in   = {q_ff[DW-2:0], ge};
         rem_in = ge ? diffv[SW-1:0] : trial[SW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== hw/rtl/prpi_adj_mem.sv =====
// Adjacency column memory: one row per target vertex, one bit per source.
module prpi_adj_mem import prpi_pkg::*; #(
   parameter int DEPTH = MAX_VERTICES_DEF,
   parameter int AW    = $clog2(MAX_VERTICES_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [DEPTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [DEPTH-1:0] wr_data
);
   logic [DEPTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] data_ff;
   logic             vld_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff  <= mem[rd_addr];
         vld_q_ff <= valid_ff[rd_addr];
      end
   end

   // rows never written since the last clear read as zero
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = vld_q_ff ? data_ff : '0;

endmodule

// ===== hw/rtl/prpi_vtx_mem.sv =====
// Vertex memory: out-degree, rank and per-iteration contribution per vertex.
module prpi_vtx_mem import prpi_pkg::*; #(
   parameter int DEPTH = MAX_VERTICES_DEF,
   parameter int AW    = $clog2(MAX_VERTICES_DEF),
   parameter int RW    = RANK_FRAC_DEF + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [DEG_W-1:0] rd_deg,
   output logic [RW-1:0]    rd_rank,
   output logic [RW-1:0]    rd_contrib,
   input  vtx_we_type       we,
   input  logic [AW-1:0]    wr_addr,
   input  logic [DEG_W-1:0] wr_deg,
   input  logic [RW-1:0]    wr_rank,
   input  logic [RW-1:0]    wr_contrib
);
   logic [DEG_W-1:0] deg_mem [DEPTH];
   logic [RW-1:0]    rank_mem [DEPTH];
   logic [RW-1:0]    contrib_mem [DEPTH];
   logic [DEPTH-1:0] deg_valid_ff;
   logic [DEG_W-1:0] deg_q_ff;
   logic             deg_vld_q_ff;
   logic [RW-1:0]    rank_q_ff;
   logic [RW-1:0]    contrib_q_ff;

   always_ff @(posedge clock) begin
      if (we.deg) begin
         deg_mem[wr_addr] <= wr_deg;
      end
      if (we.rank) begin
         rank_mem[wr_addr] <= wr_rank;
      end
      if (we.contrib) begin
         contrib_mem[wr_addr] <= wr_contrib;
      end
      if (rd_en) begin
         deg_q_ff     <= deg_mem[rd_addr];
         deg_vld_q_ff <= deg_valid_ff[rd_addr];
         rank_q_ff    <= rank_mem[rd_addr];
         contrib_q_ff <= contrib_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         deg_valid_ff <= '0;
      end else if (we.deg) begin
         deg_valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_deg     = deg_vld_q_ff ? deg_q_ff : '0;
   assign rd_rank    = rank_q_ff;
   assign rd_contrib = contrib_q_ff;

endmodule

// ===== hw/rtl/pagerank_power_iteration.sv =====
// Top level of the PageRank power-iteration engine with sink redistribution.
//
// Edges stream in on req_* one transaction per cycle; each edge costs a
// read-modify-write of the adjacency column and the source out-degree, with
// forwarding so back-to-back edges to the same vertex stay exact. Duplicate
// edges and edges with an endpoint at or above the vertex count (clamped to
// 1..MAX_VERTICES) are dropped. The transaction marked tlast starts the rank
// computation and holds req_tready low until all results are delivered. Setup
// divides to get the start and teleport ranks and writes the start rank to every
// vertex. Each iteration has a contribution pass (one serial division of
// DW = RANK_FRAC_BITS+1+log2(MAX_VERTICES) bits per non-sink vertex, none per
// sink), a division for the sink share, an accumulation pass that reads one
// contribution a cycle through the vertex memory's single read port, and a
// convergence check. Results then leave on rsp_* one vertex at a time, each
// held until taken, and the graph state is cleared when the last one is taken.
// Configuration writes on csr_* are always taken and must be issued only while idle.
module pagerank_power_iteration import prpi_pkg::*; #(
   parameter int MAX_VERTICES   = MAX_VERTICES_DEF,
   parameter int RANK_FRAC_BITS = RANK_FRAC_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // edge transactions
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // source_vertex[5:0], dest_vertex[11:6]
   input  logic [0:0]            req_tuser,   // edge_valid
   input  logic                  req_tlast,   // last_edge
   // rank results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // vertex_index[5:0], rank_value[38:6]
   output logic [0:0]            rsp_tuser,   // converged
   output logic                  rsp_tlast,   // last_rank
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int VW      = $clog2(MAX_VERTICES);
   localparam int NW      = VW + 1;
   localparam int RW      = RANK_FRAC_BITS + 1;
   localparam int SUM_W   = RW + VW;
   localparam int ACC_W   = SUM_W + 1;
   localparam int PROD_W  = DAMP_W + SUM_W;
   localparam int DIFFX_W = SUM_W + 32 - RANK_FRAC_BITS;

   typedef enum logic [20:0] {
      S_LOAD        = 21'd1,
      S_DRAIN       = 21'd2,
      S_START_DIV   = 21'd4,
      S_START_WAIT  = 21'd8,
      S_TELE_WAIT   = 21'd16,
      S_INIT        = 21'd32,
      S_SCAN_RD     = 21'd64,
      S_SCAN_MUL    = 21'd128,
      S_SCAN_DIV    = 21'd256,
      S_SCAN_WAIT   = 21'd512,
      S_SPREAD_MUL  = 21'd1024,
      S_SPREAD_DIV  = 21'd2048,
      S_SPREAD_WAIT = 21'd4096,
      S_COL_RD      = 21'd8192,
      S_ACC         = 21'd16384,
      S_UPD_RD      = 21'd32768,
      S_UPD_WR      = 21'd65536,
      S_CHECK       = 21'd131072,
      S_OUT_RD      = 21'd262144,
      S_OUT_LD      = 21'd524288,
      S_OUT_HOLD    = 21'd1048576
   } state_type;

   // configuration
   logic [VC_W-1:0]   vcount_ff, vcount_in;
   logic [DAMP_W-1:0] damp_ff, damp_in;
   logic [EPS_W-1:0]  eps_ff, eps_in;
   logic [ITER_W-1:0] maxit_ff, maxit_in;

   logic [NW-1:0]     n;
   logic [NW-1:0]     n_m1;
   logic [VW-1:0]     n_last;
   logic [DAMP_W-1:0] dsat;
   logic [DAMP_W-1:0] dcomp;
   logic [ITER_W-1:0] cap;

   // control and datapath registers
   state_type         state_ff, state_in;
   logic [VW-1:0]     idx_ff, idx_in;
   logic [VW-1:0]     rdu_ff, rdu_in;
   logic [RW-1:0]     start_ff, start_in;
   logic [RW-1:0]     tele_ff, tele_in;
   logic [ACC_W-1:0]  base_ff, base_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  sinks_ff, sinks_in;
   logic [SUM_W-1:0]  diff_ff, diff_in;
   logic [SUM_W-1:0]  prod_ff, prod_in;
   logic [DEG_W-1:0]  degq_ff, degq_in;
   logic [ITER_W-1:0] iter_cnt_ff, iter_cnt_in;
   logic              conv_ff, conv_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [OUT_RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   logic                  rsp_conv_ff, rsp_conv_in;
   logic                  rsp_last_ff, rsp_last_in;

   // edge pipeline and forwarding
   logic                    s1_vld_ff, s1_vld_in;
   logic [VW-1:0]           s1_src_ff, s1_src_in;
   logic [VW-1:0]           s1_dst_ff, s1_dst_in;
   logic                    fa_en_ff, fa_en_in;
   logic [VW-1:0]           fa_addr_ff, fa_addr_in;
   logic [MAX_VERTICES-1:0] fa_data_ff, fa_data_in;
   logic                    fd_en_ff, fd_en_in;
   logic [VW-1:0]           fd_addr_ff, fd_addr_in;
   logic [DEG_W-1:0]        fd_data_ff, fd_data_in;

   logic                    req_hs;
   logic                    rsp_hs;
   logic                    take;
   logic [FIELD_W-1:0]      src6;
   logic [FIELD_W-1:0]      dst6;
   logic [MAX_VERTICES-1:0] col;
   logic [DEG_W-1:0]        deg_cur;
   logic                    e_wr;
   logic [MAX_VERTICES-1:0] col_new;
   logic [DEG_W-1:0]        deg_new;

   // memory ports
   logic                    adj_rd_en;
   logic [VW-1:0]           adj_rd_addr;
   logic [MAX_VERTICES-1:0] adj_rd_data;
   logic                    vtx_rd_en;
   logic [VW-1:0]           vtx_rd_addr;
   logic [DEG_W-1:0]        vtx_rd_deg;
   logic [RW-1:0]           vtx_rd_rank;
   logic [RW-1:0]           vtx_rd_contrib;
   vtx_we_type              vtx_we;
   logic [VW-1:0]           vtx_wr_addr;
   logic [RW-1:0]           vtx_wr_rank;
   logic [RW-1:0]           vtx_wr_contrib;
   logic                    mem_clear;

   // divider and multiplier
   logic                    div_start;
   logic [SUM_W-1:0]        div_dividend;
   logic [DEG_W-1:0]        div_divisor;
   logic                    div_done;
   logic [SUM_W-1:0]        div_q;
   logic [SUM_W-1:0]        mul_b;
   logic [PROD_W-1:0]       product;

   // rank update
   logic [RW-1:0]           r_sat;
   logic [RW-1:0]           r_abs;
   logic [ITER_W-1:0]       cnt_next;
   logic                    conv_now;

   assign csr_ready = 1'b1;

   // --- configuration registers
   always_comb begin
      vcount_in = vcount_ff;
      damp_in   = damp_ff;
      eps_in    = eps_ff;
      maxit_in  = maxit_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_VERTEX_COUNT: vcount_in = csr_data[VC_W-1:0];
            CSR_DAMPING:      damp_in   = csr_data[DAMP_W-1:0];
            CSR_EPSILON:      eps_in    = csr_data[EPS_W-1:0];
            CSR_MAX_ITER:     maxit_in  = csr_data[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp configuration into its working range
   always_comb begin
      if (vcount_ff == '0) begin
         n = NW'(1);
      end else if (vcount_ff > VC_W'(MAX_VERTICES)) begin
         n = NW'(MAX_VERTICES);
      end else begin
         n = NW'(vcount_ff);
      end
      n_m1   = n - NW'(1);
      n_last = n_m1[VW-1:0];
      dsat   = (damp_ff > DAMP_ONE) ? DAMP_ONE : damp_ff;
      dcomp  = DAMP_ONE - dsat;
      cap    = (maxit_ff == '0) ? ITER_W'(1) : maxit_ff;
   end

   // --- edge loading
   assign req_tready = (state_ff == S_LOAD);
   assign req_hs     = req_tvalid & req_tready;
   assign rsp_hs     = rsp_valid_ff & rsp_tready;
   assign src6       = req_tdata[FIELD_W-1:0];
   assign dst6       = req_tdata[2*FIELD_W-1:FIELD_W];
   assign take       = req_hs && req_tuser[0]
                       && (VC_W'(src6) < VC_W'(n)) && (VC_W'(dst6) < VC_W'(n));

   always_comb begin
      s1_vld_in = take;
      s1_src_in = src6[VW-1:0];
      s1_dst_in = dst6[VW-1:0];
      // pick up the write that landed in the same cycle as this read
      col     = (fa_en_ff && fa_addr_ff == s1_dst_ff) ? fa_data_ff : adj_rd_data;
      deg_cur = (fd_en_ff && fd_addr_ff == s1_src_ff) ? fd_data_ff : vtx_rd_deg;
      e_wr    = s1_vld_ff && !col[s1_src_ff];
      col_new = col | (MAX_VERTICES'(1) << s1_src_ff);
      deg_new = deg_cur + DEG_W'(1);
      fa_en_in   = e_wr;
      fa_addr_in = s1_dst_ff;
      fa_data_in = col_new;
      fd_en_in   = e_wr;
      fd_addr_in = s1_src_ff;
      fd_data_in = deg_new;
   end

   // --- shared multiplier: damping times a rank or the sink sum
   assign mul_b   = (state_ff == S_SPREAD_MUL) ? sinks_ff : SUM_W'(vtx_rd_rank);
   assign product = PROD_W'(dsat) * PROD_W'(mul_b);
   assign prod_in = product[DAMP_SHIFT +: SUM_W];

   // --- rank update arithmetic
   always_comb begin
      r_sat    = (acc_ff[ACC_W-1:RW] != '0) ? {RW{1'b1}} : acc_ff[RW-1:0];
      r_abs    = (r_sat >= vtx_rd_rank) ? (r_sat - vtx_rd_rank) : (vtx_rd_rank - r_sat);
      cnt_next = iter_cnt_ff + ITER_W'(1);
      conv_now = (DIFFX_W'(diff_ff) << (32 - RANK_FRAC_BITS)) <= DIFFX_W'(eps_ff);
   end

   // --- sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rdu_in       = rdu_ff;
      start_in     = start_ff;
      tele_in      = tele_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      sinks_in     = sinks_ff;
      diff_in      = diff_ff;
      degq_in      = degq_ff;
      iter_cnt_in  = iter_cnt_ff;
      conv_in      = conv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_conv_in  = rsp_conv_ff;
      rsp_last_in  = rsp_last_ff;

      adj_rd_en      = take;
      adj_rd_addr    = dst6[VW-1:0];
      vtx_rd_en      = take;
      vtx_rd_addr    = src6[VW-1:0];
      vtx_we         = '{deg: e_wr, rank: 1'b0, contrib: 1'b0};
      vtx_wr_addr    = s1_src_ff;
      vtx_wr_rank    = start_ff;
      vtx_wr_contrib = '0;
      mem_clear      = 1'b0;

      div_start    = 1'b0;
      div_dividend = SUM_W'(1) << RANK_FRAC_BITS;
      div_divisor  = DEG_W'(n);

      case (state_ff)
         S_LOAD: begin
            if (req_hs && req_tlast) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // let the final edge finish its write
            state_in = S_START_DIV;
         end
         S_START_DIV: begin
            div_start = 1'b1;
            state_in  = S_START_WAIT;
         end
         S_START_WAIT: begin
            if (div_done) begin
               start_in     = div_q[RW-1:0];
               div_start    = 1'b1;
               div_dividend = SUM_W'(dcomp) << (RANK_FRAC_BITS - DAMP_SHIFT);
               state_in     = S_TELE_WAIT;
            end
         end
         S_TELE_WAIT: begin
            if (div_done) begin
               tele_in  = div_q[RW-1:0];
               idx_in   = '0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            vtx_we.rank = 1'b1;
            vtx_wr_addr = idx_ff;
            vtx_wr_rank = start_ff;
            if (idx_ff == n_last) begin
               idx_in      = '0;
               sinks_in    = '0;
               diff_in     = '0;
               iter_cnt_in = '0;
               state_in    = S_SCAN_RD;
            end else begin
               idx_in = idx_ff + VW'(1);
            end
         end
         S_SCAN_RD: begin
            vtx_rd_en   = 1'b1;
            vtx_rd_addr = idx_ff;
            state_in    = S_SCAN_MUL;
         end
         S_SCAN_MUL: begin
            if (vtx_rd_deg == '0) begin
               // sink: its rank joins the evenly spread share
               sinks_in       = sinks_ff + SUM_W'(vtx_rd_rank);
               vtx_we.contrib = 1'b1;
               vtx_wr_addr    = idx_ff;
               vtx_wr_contrib = '0;
               if (idx_ff == n_last) begin
                  state_in = S_SPREAD_MUL;
               end else begin
                  idx_in   = idx_ff + VW'(1);
                  state_in = S_SCAN_RD;
               end
            end else begin
               degq_in  = vtx_rd_deg;
               state_in = S_SCAN_DIV;
            end
         end
         S_SCAN_DIV: begin
            div_start    = 1'b1;
            div_dividend = prod_ff;
            div_divisor  = degq_ff;
            state_in     = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            if (div_done) begin
               vtx_we.contrib = 1'b1;
               vtx_wr_addr    = idx_ff;
               vtx_wr_contrib = div_q[RW-1:0];
               if (idx_ff == n_last) begin
                  state_in = S_SPREAD_MUL;
               end else begin
                  idx_in   = idx_ff + VW'(1);
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SPREAD_MUL: begin
            state_in = S_SPREAD_DIV;
         end
         S_SPREAD_DIV: begin
            div_start    = 1'b1;
            div_dividend = prod_ff;
            state_in     = S_SPREAD_WAIT;
         end
         S_SPREAD_WAIT: begin
            if (div_done) begin
               base_in  = ACC_W'(tele_ff) + ACC_W'(div_q[RW-1:0]);
               idx_in   = '0;
               state_in = S_COL_RD;
            end
         end
         S_COL_RD: begin
            adj_rd_en   = 1'b1;
            adj_rd_addr = idx_ff;
            vtx_rd_en   = 1'b1;
            vtx_rd_addr = '0;
            rdu_in      = '0;
            acc_in      = base_ff;
            state_in    = S_ACC;
         end
         S_ACC: begin
            // add the in-neighbour's share, fetch the next one
            if (adj_rd_data[rdu_ff]) begin
               acc_in = acc_ff + ACC_W'(vtx_rd_contrib);
            end
            if (rdu_ff == n_last) begin
               state_in = S_UPD_RD;
            end else begin
               vtx_rd_en   = 1'b1;
               vtx_rd_addr = rdu_ff + VW'(1);
               rdu_in      = rdu_ff + VW'(1);
            end
         end
         S_UPD_RD: begin
            vtx_rd_en   = 1'b1;
            vtx_rd_addr = idx_ff;
            state_in    = S_UPD_WR;
         end
         S_UPD_WR: begin
            vtx_we.rank = 1'b1;
            vtx_wr_addr = idx_ff;
            vtx_wr_rank = r_sat;
            diff_in     = diff_ff + SUM_W'(r_abs);
            if (idx_ff == n_last) begin
               state_in = S_CHECK;
            end else begin
               idx_in   = idx_ff + VW'(1);
               state_in = S_COL_RD;
            end
         end
         S_CHECK: begin
            iter_cnt_in = cnt_next;
            idx_in      = '0;
            if (conv_now) begin
               conv_in  = 1'b1;
               state_in = S_OUT_RD;
            end else if (cnt_next >= cap) begin
               conv_in  = 1'b0;
               state_in = S_OUT_RD;
            end else begin
               sinks_in = '0;
               diff_in  = '0;
               state_in = S_SCAN_RD;
            end
         end
         S_OUT_RD: begin
            vtx_rd_en   = 1'b1;
            vtx_rd_addr = idx_ff;
            state_in    = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = FIELD_W'(idx_ff);
            rsp_rank_in  = OUT_RANK_W'(vtx_rd_rank);
            rsp_conv_in  = conv_ff;
            rsp_last_in  = (idx_ff == n_last);
            state_in     = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp_hs) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  // drop the graph for the next run
                  mem_clear   = 1'b1;
                  iter_cnt_in = '0;
                  state_in    = S_LOAD;
               end else begin
                  idx_in   = idx_ff + VW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         vcount_ff    <= VC_RESET;
         damp_ff      <= DAMP_RESET;
         eps_ff       <= EPS_RESET;
         maxit_ff     <= MAXIT_RESET;
         iter_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         fa_en_ff     <= 1'b0;
         fd_en_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         damp_ff      <= damp_in;
         eps_ff       <= eps_in;
         maxit_ff     <= maxit_in;
         iter_cnt_ff  <= iter_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= s1_vld_in;
         fa_en_ff     <= fa_en_in;
         fd_en_ff     <= fd_en_in;
      end
      idx_ff       <= idx_in;
      rdu_ff       <= rdu_in;
      start_ff     <= start_in;
      tele_ff      <= tele_in;
      base_ff      <= base_in;
      acc_ff       <= acc_in;
      sinks_ff     <= sinks_in;
      diff_ff      <= diff_in;
      prod_ff      <= (state_ff == S_SCAN_MUL || state_ff == S_SPREAD_MUL) ? prod_in : prod_ff;
      degq_ff      <= degq_in;
      conv_ff      <= conv_in;
      rsp_index_ff <= rsp_index_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_conv_ff  <= rsp_conv_in;
      rsp_last_ff  <= rsp_last_in;
      s1_src_ff    <= s1_src_in;
      s1_dst_ff    <= s1_dst_in;
      fa_addr_ff   <= fa_addr_in;
      fa_data_ff   <= fa_data_in;
      fd_addr_ff   <= fd_addr_in;
      fd_data_ff   <= fd_data_in;
   end

   // --- units
   prpi_adj_mem #(
      .DEPTH (MAX_VERTICES),
      .AW    (VW)
   ) u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (mem_clear),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data),
      .wr_en   (e_wr),
      .wr_addr (s1_dst_ff),
      .wr_data (col_new)
   );

   prpi_vtx_mem #(
      .DEPTH (MAX_VERTICES),
      .AW    (VW),
      .RW    (RW)
   ) u_vtx_mem (
      .clock      (clock),
      .reset      (reset),
      .clear      (mem_clear),
      .rd_en      (vtx_rd_en),
      .rd_addr    (vtx_rd_addr),
      .rd_deg     (vtx_rd_deg),
      .rd_rank    (vtx_rd_rank),
      .rd_contrib (vtx_rd_contrib),
      .we         (vtx_we),
      .wr_addr    (vtx_wr_addr),
      .wr_deg     (deg_new),
      .wr_rank    (vtx_wr_rank),
      .wr_contrib (vtx_wr_contrib)
   );

   prpi_div #(
      .DW (SUM_W),
      .SW (DEG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // --- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_rank_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_conv_ff;
   assign rsp_tlast  = rsp_last_ff;

   // --- assertions
   a_no_load_while_output: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("edge accepted while a rank result is pending");

   a_degree_write_in_load: assert property (@(posedge clock) disable iff (reset)
      vtx_we.deg |-> (state_ff == S_LOAD || state_ff == S_DRAIN))
      else $error("out-degree written outside edge loading");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_hs && rsp_last_ff) |=> (iter_cnt_ff == '0 && state_ff == S_LOAD))
      else $error("graph not released after the last rank");

endmodule
